FILE: design/plc_pkg.sv
// shared codes and control types for the positional list engine
`default_nettype none
package plc_pkg;

   localparam int KEY_W = 32;

   localparam logic [2:0] REQ_INSERT      = 3'd0;
   localparam logic [2:0] REQ_APPEND      = 3'd1;
   localparam logic [2:0] REQ_REMOVE      = 3'd2;
   localparam logic [2:0] REQ_REMOVE_LAST = 3'd3;
   localparam logic [2:0] REQ_READ        = 3'd4;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_FULL  = 2'd3;

   typedef struct packed {
      logic load;
      logic insert;
      logic remove;
   } cell_cmd_type;

endpackage
`default_nettype wire

FILE: design/plc_cell.sv
// one storage cell of the list chain
`default_nettype none
module plc_cell
   import plc_pkg::*;
#(
   parameter int INDEX = 0,
   parameter int CW    = 7
) (
   input  wire                      clock,
   input  cell_cmd_type             cmd,
   input  wire  [CW-1:0]            pos,
   input  wire  signed [KEY_W-1:0]  key,
   input  wire  signed [KEY_W-1:0]  left_key,
   input  wire  signed [KEY_W-1:0]  right_key,
   output logic signed [KEY_W-1:0]  entry,
   output logic signed [KEY_W-1:0]  tap
);

   localparam logic [CW-1:0] IDX = CW'(INDEX);

   logic signed [KEY_W-1:0] entry_ff, entry_in;
   logic signed [KEY_W-1:0] tap_ff, tap_in;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (IDX > pos) begin
            entry_in = left_key;
         end else if (IDX == pos) begin
            entry_in = key;
         end
      end else if (cmd.remove) begin
         if (IDX >= pos) begin
            entry_in = right_key;
         end
      end
      tap_in = (IDX == pos) ? entry_ff : '0;
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (cmd.load) begin
         tap_ff <= tap_in;
      end
   end

   assign entry = entry_ff;
   assign tap   = tap_ff;

endmodule
`default_nettype wire

FILE: design/positional_list_engine.sv
// top level: request decode, cell chain and response register
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_stall | req_type, req_position, req_key_in
//  rsp     | out       | rsp_valid / rsp_stall | rsp_status, rsp_key_out, rsp_count
//
// one request per cycle while req_stall is low; each response then passes the
// middle stage and the response register; the whole chain shifts in the transfer
// cycle; the picked key is or-reduced from the cell taps into the response register
// synchronous reset empties the list at once; cell contents are left as they are
// a stalled response holds one more request in the middle stage, then req_stall rises
`default_nettype none
module positional_list_engine
   import plc_pkg::*;
#(
   parameter int CAPACITY = 64,
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  wire  [2:0]               req_type,
   input  wire  [CW-1:0]            req_position,
   input  wire  signed [KEY_W-1:0]  req_key_in,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output logic [1:0]               rsp_status,
   output logic signed [KEY_W-1:0]  rsp_key_out,
   output logic [CW-1:0]            rsp_count
);

   localparam logic [CW-1:0] CAP = CW'(CAPACITY);

   logic [CW-1:0] fill_ff, fill_in;
   logic          mid_valid_ff, mid_valid_in;
   logic [1:0]    mid_status_ff;
   logic          mid_use_key_ff, mid_use_tap_ff;
   logic signed [KEY_W-1:0] mid_key_ff;
   logic [CW-1:0] mid_count_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff;
   logic signed [KEY_W-1:0] rsp_key_ff;
   logic [CW-1:0] rsp_count_ff;

   logic          accept, mid_move;
   logic          full, empty;
   logic [1:0]    status;
   logic          use_key, use_tap;
   logic [CW-1:0] eff_pos;
   cell_cmd_type  cmd;
   logic signed [KEY_W-1:0] tap_or;

   logic signed [KEY_W-1:0] entry_w [CAPACITY];
   logic signed [KEY_W-1:0] tap_w   [CAPACITY];

   assign mid_move  = mid_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = mid_valid_ff && rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign full  = (fill_ff == CAP);
   assign empty = (fill_ff == '0);

   always_comb begin
      status  = ST_OK;
      use_key = 1'b0;
      use_tap = 1'b0;
      eff_pos = req_position;
      cmd     = '0;
      fill_in = fill_ff;
      unique case (req_type)
         REQ_INSERT: begin
            if (req_position > fill_ff) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               cmd.insert = 1'b1;
               use_key    = 1'b1;
               fill_in    = fill_ff + 1'b1;
            end
         end
         REQ_APPEND: begin
            eff_pos = fill_ff;
            if (full) begin
               status = ST_FULL;
            end else begin
               cmd.insert = 1'b1;
               use_key    = 1'b1;
               fill_in    = fill_ff + 1'b1;
            end
         end
         REQ_REMOVE: begin
            if (empty) begin
               status = ST_EMPTY;
            end else if (req_position >= fill_ff) begin
               status = ST_RANGE;
            end else begin
               cmd.remove = 1'b1;
               use_tap    = 1'b1;
               fill_in    = fill_ff - 1'b1;
            end
         end
         REQ_REMOVE_LAST: begin
            eff_pos = fill_ff - 1'b1;
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               cmd.remove = 1'b1;
               use_tap    = 1'b1;
               fill_in    = fill_ff - 1'b1;
            end
         end
         REQ_READ: begin
            if (empty) begin
               status = ST_EMPTY;
            end else if (req_position >= fill_ff) begin
               status = ST_RANGE;
            end else begin
               use_tap = 1'b1;
            end
         end
         default: begin
            status = ST_OK;
         end
      endcase
      cmd.load = accept;
      if (!accept) begin
         cmd.insert = 1'b0;
         cmd.remove = 1'b0;
         fill_in    = fill_ff;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [KEY_W-1:0] left_key, right_key;
      if (i == 0) begin : g_first
         assign left_key = '0;
      end else begin : g_left
         assign left_key = entry_w[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_key = entry_w[i];
      end else begin : g_right
         assign right_key = entry_w[i+1];
      end
      plc_cell #(.INDEX(i), .CW(CW)) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .pos       (eff_pos),
         .key       (req_key_in),
         .left_key  (left_key),
         .right_key (right_key),
         .entry     (entry_w[i]),
         .tap       (tap_w[i])
      );
   end

   always_comb begin
      tap_or = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tap_or = tap_or | tap_w[i];
      end
   end

   always_comb begin
      mid_valid_in = mid_valid_ff;
      if (accept) begin
         mid_valid_in = 1'b1;
      end else if (mid_move) begin
         mid_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (mid_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         mid_valid_ff <= mid_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mid_status_ff  <= status;
         mid_use_key_ff <= use_key;
         mid_use_tap_ff <= use_tap;
         mid_key_ff     <= req_key_in;
         mid_count_ff   <= fill_in;
      end
      if (mid_move) begin
         rsp_status_ff <= mid_status_ff;
         rsp_count_ff  <= mid_count_ff;
         if (mid_use_tap_ff) begin
            rsp_key_ff <= tap_or;
         end else if (mid_use_key_ff) begin
            rsp_key_ff <= mid_key_ff;
         end else begin
            rsp_key_ff <= '0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_key_out = rsp_key_ff;
   assign rsp_count   = rsp_count_ff;

endmodule
`default_nettype wire

FILE: design/plc_checker.sv
// port-level checks for the positional list engine, bound to the top level
`default_nettype none
module plc_checker
   import plc_pkg::*;
#(
   parameter int CAPACITY = 64,
   parameter int CW       = $clog2(CAPACITY + 1)
) (
   input wire                      clock,
   input wire                      reset,
   input wire                      rsp_valid,
   input wire                      rsp_stall,
   input wire [1:0]                rsp_status,
   input wire signed [KEY_W-1:0]   rsp_key_out,
   input wire [CW-1:0]             rsp_count
);

   localparam logic [CW-1:0] CAP = CW'(CAPACITY);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_key_out)
         && $stable(rsp_status) && $stable(rsp_count))
      else $error("stalled response changed");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= CAP)
      else $error("response count above capacity");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_count == CAP)
      else $error("full status with room left");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_count == '0)
      else $error("empty status with keys held");

   a_fail_key: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_key_out == '0)
      else $error("failed request returned a key");

endmodule

bind positional_list_engine plc_checker #(.CAPACITY(CAPACITY), .CW(CW)) u_plc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_status  (rsp_status),
   .rsp_key_out (rsp_key_out),
   .rsp_count   (rsp_count)
);
`default_nettype wire

FILE: verif/testbench.sv
// testbench for positional_list_engine: directed and random requests against a shadow list
`timescale 1ns / 100ps
module testbench;
   import plc_pkg::*;

   localparam int LIST_DEPTH = 64;
   localparam int POS_W = 7;
   localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
   localparam int MODE_GROW = 0;
   localparam int MODE_SHRINK = 1;
   localparam int MODE_MIX = 2;
   localparam int RANDOM_ITEMS = 950;

   typedef struct packed {
      logic [2:0]              kind;
      logic [POS_W-1:0]        pos;
      logic [1:0]              status;
      logic signed [KEY_W-1:0] key;
      logic [POS_W-1:0]        count;
   } list_outcome_type;

   class list_shadow_type;
      logic signed [KEY_W-1:0] keys[$];
      list_outcome_type        pending_outcomes[$];
      int                      errors;
      int                      checked;
      int                      requests;
      int                      status_hits[4];

      function int held();
         return keys.size();
      endfunction

      function int outstanding();
         return pending_outcomes.size();
      endfunction

      function void note_request(logic [2:0] kind, logic [POS_W-1:0] pos,
                                 logic signed [KEY_W-1:0] key);
         list_outcome_type o;
         o.kind = kind;
         o.pos = pos;
         o.status = ST_OK;
         o.key = '0;
         case (kind)
            REQ_INSERT: begin
               if (pos > keys.size()) o.status = ST_RANGE;
               else if (keys.size() >= LIST_DEPTH) o.status = ST_FULL;
               else begin
                  keys.insert(pos, key);
                  o.key = key;
               end
            end
            REQ_APPEND: begin
               if (keys.size() >= LIST_DEPTH) o.status = ST_FULL;
               else begin
                  keys.push_back(key);
                  o.key = key;
               end
            end
            REQ_REMOVE: begin
               if (keys.size() == 0) o.status = ST_EMPTY;
               else if (pos >= keys.size()) o.status = ST_RANGE;
               else begin
                  o.key = keys[pos];
                  keys.delete(pos);
               end
            end
            REQ_REMOVE_LAST: begin
               if (keys.size() == 0) o.status = ST_EMPTY;
               else o.key = keys.pop_back();
            end
            REQ_READ: begin
               if (keys.size() == 0) o.status = ST_EMPTY;
               else if (pos >= keys.size()) o.status = ST_RANGE;
               else o.key = keys[pos];
            end
            default: ;
         endcase
         o.count = POS_W'(keys.size());
         status_hits[o.status]++;
         requests++;
         pending_outcomes.push_back(o);
      endfunction

      function void check_response(logic [1:0] status, logic signed [KEY_W-1:0] key,
                                   logic [POS_W-1:0] count);
         list_outcome_type o;
         if (pending_outcomes.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: response with nothing outstanding:", $time,
                        " status %0d key %0d count %0d", status, key, count);
         end else begin
            o = pending_outcomes.pop_front();
            checked++;
            if (status !== o.status || key !== o.key || count !== o.count) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: mismatch for type %0d pos %0d:", $time, o.kind, o.pos,
                           " exp status %0d key %0d count %0d,",
                           o.status, o.key, o.count,
                           " got status %0d key %0d count %0d", status, key, count);
            end
         end
      endfunction
   endclass

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [2:0]               req_type = REQ_READ;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [KEY_W-1:0]  req_key_in = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [1:0]               rsp_status;
   logic signed [KEY_W-1:0]  rsp_key_out;
   logic [POS_W-1:0]         rsp_count;

   list_shadow_type shadow;
   bit              gaps_on = 1'b1;
   int              full_hits;

   positional_list_engine #(.CAPACITY(LIST_DEPTH)) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_type     (req_type),
      .req_position (req_position),
      .req_key_in   (req_key_in),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_key_out  (rsp_key_out),
      .rsp_count    (rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5000000;
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      rsp_stall <= gaps_on && ($urandom_range(0, 99) < 31);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         shadow.check_response(rsp_status, rsp_key_out, rsp_count);
   end

   task automatic send_request(input logic [2:0] kind, input logic [POS_W-1:0] pos,
                               input logic signed [KEY_W-1:0] key);
      while (gaps_on && $urandom_range(0, 99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_position <= pos;
      req_key_in <= key;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      shadow.note_request(kind, pos, key);
      if (shadow.held() == LIST_DEPTH) full_hits++;
   endtask

   function automatic logic [2:0] choose_kind(int mode);
      int roll;
      roll = $urandom_range(0, 99);
      if (mode == MODE_GROW) begin
         if (roll < 50) return REQ_INSERT;
         if (roll < 85) return REQ_APPEND;
      end else if (mode == MODE_SHRINK) begin
         if (roll < 40) return REQ_REMOVE;
         if (roll < 75) return REQ_REMOVE_LAST;
         if (roll < 90) return REQ_READ;
      end
      case ($urandom_range(0, 4))
         0: return REQ_INSERT;
         1: return REQ_APPEND;
         2: return REQ_REMOVE;
         3: return REQ_REMOVE_LAST;
         default: return REQ_READ;
      endcase
   endfunction

   function automatic logic [POS_W-1:0] choose_position(logic [2:0] kind, int held);
      int roll;
      int top;
      roll = $urandom_range(0, 99);
      top = (kind == REQ_INSERT) ? held : held - 1;
      if (roll < 70) return (top > 0) ? POS_W'($urandom_range(0, top)) : '0;
      if (roll < 85) begin
         case ($urandom_range(0, 3))
            0: return POS_W'(held);
            1: return POS_W'(held + 1);
            2: return '0;
            default: return POS_W'(LIST_DEPTH);
         endcase
      end
      return POS_W'($urandom_range(0, (1 << POS_W) - 1));
   endfunction

   function automatic logic signed [KEY_W-1:0] choose_key();
      if ($urandom_range(0, 99) < 10) begin
         case ($urandom_range(0, 3))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return 32'sh0;
            default: return -32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   task automatic run_random(input int target);
      int               sent;
      int               burst;
      int               mode;
      logic [2:0]       kind;
      logic [POS_W-1:0] pos;
      sent = 0;
      burst = 0;
      mode = MODE_GROW;
      // open with a fill to capacity, then probe the full list
      while (shadow.held() < LIST_DEPTH) begin
         kind = ($urandom_range(0, 1) != 0) ? REQ_APPEND : REQ_INSERT;
         send_request(kind, POS_W'($urandom_range(0, shadow.held())), choose_key());
         sent++;
      end
      send_request(REQ_INSERT, POS_W'(LIST_DEPTH + 1), choose_key());
      send_request(REQ_INSERT, POS_W'($urandom_range(0, LIST_DEPTH)), choose_key());
      send_request(REQ_APPEND, '0, choose_key());
      sent += 3;
      while (sent < target) begin
         if (burst == 0) begin
            burst = $urandom_range(30, 90);
            mode = $urandom_range(MODE_GROW, MODE_MIX);
         end
         burst--;
         gaps_on = !(sent >= 350 && sent < 550);
         if ($urandom_range(0, 99) < 3) begin
            send_request(3'(REQ_UNUSED_LO + $urandom_range(0, 2)),
                         POS_W'($urandom_range(0, (1 << POS_W) - 1)), $urandom);
         end else begin
            kind = choose_kind(mode);
            pos = choose_position(kind, shadow.held());
            send_request(kind, pos, choose_key());
            sent++;
         end
      end
   endtask

   initial begin
      shadow = new;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(REQ_READ, 0, 32'sd5);
      send_request(REQ_REMOVE, 0, 32'sd0);
      send_request(REQ_REMOVE_LAST, 0, 32'sd0);
      send_request(REQ_INSERT, 1, 32'sd9);
      send_request(REQ_INSERT, 0, 32'sh8000_0000);
      send_request(REQ_APPEND, 0, 32'sh7fff_ffff);
      send_request(REQ_INSERT, 1, -32'sd1);
      send_request(REQ_INSERT, 3, 32'sd0);
      send_request(REQ_INSERT, 7'h7f, 32'sd3);
      send_request(REQ_READ, 0, 32'sd0);
      send_request(REQ_READ, 3, 32'sd0);
      send_request(REQ_READ, 4, 32'sd0);
      send_request(REQ_READ, 7'h7f, 32'sd0);
      send_request(REQ_REMOVE, 7'h7f, 32'sd0);
      send_request(REQ_REMOVE, 1, 32'sd0);
      send_request(REQ_REMOVE_LAST, 7'h55, 32'sh1234_5678);
      send_request(REQ_UNUSED_LO, 7'h2a, 32'sh5555_5555);
      send_request(REQ_UNUSED_LO + 3'd1, 7'h7f, -32'sd1);
      send_request(REQ_UNUSED_LO + 3'd2, 0, 32'sh2aaa_aaaa);
      send_request(REQ_REMOVE, 0, 32'sd0);
      send_request(REQ_REMOVE, 0, 32'sd0);
      send_request(REQ_APPEND, 7'h7f, 32'sh5555_5555);
      send_request(REQ_READ, 0, 32'sd0);
      send_request(REQ_REMOVE_LAST, 0, 32'sd0);

      run_random(RANDOM_ITEMS);
      req_valid <= 1'b0;
      gaps_on = 1'b1;

      while (shadow.outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("covered %0d requests, %0d responses checked, list full after %0d transfers",
               shadow.requests, shadow.checked, full_hits);
      $display("status ok %0d, empty %0d, out of range %0d, full %0d",
               shadow.status_hits[ST_OK], shadow.status_hits[ST_EMPTY],
               shadow.status_hits[ST_RANGE], shadow.status_hits[ST_FULL]);
      if (shadow.errors == 0 && shadow.outstanding() == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", shadow.errors);
         $display("FAIL");
      end
      $finish;
   end

endmodule
